// ===== rtl/lr_pkg.sv =====
// Package for the line rasterizer: default widths and the command/status
// structs that join the controller and the datapath. No dependencies.
`default_nettype none

package lr_pkg;

	localparam int COORD_BITS_DEF = 6;
	localparam int COLOR_BITS     = 32;

	typedef struct packed {
		logic load;
		logic div_step;
		logic fix;
		logic advance;
	} lr_cmd_t;

	typedef struct packed {
		logic general;
		logic last;
	} lr_sts_t;

endpackage

`default_nettype wire

// ===== rtl/lr_seg_if.sv =====
// Segment request channel: valid/ready handshake with two endpoints and a color.
// Depends on lr_pkg for default widths.
`default_nettype none

interface lr_seg_if #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
);
	logic                           valid;
	logic                           ready;
	logic [COORD_BITS-1:0]          start_x;
	logic [COORD_BITS-1:0]          start_y;
	logic [COORD_BITS-1:0]          end_x;
	logic [COORD_BITS-1:0]          end_y;
	logic [lr_pkg::COLOR_BITS-1:0]  line_color;

	modport source (output valid, start_x, start_y, end_x, end_y, line_color, input ready);
	modport sink   (input valid, start_x, start_y, end_x, end_y, line_color, output ready);
endinterface

`default_nettype wire

// ===== rtl/lr_pix_if.sv =====
// Pixel request channel: valid/ready handshake with coordinates, color and last flag.
// Depends on lr_pkg for default widths.
`default_nettype none

interface lr_pix_if #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
);
	logic                           valid;
	logic                           ready;
	logic [COORD_BITS-1:0]          pixel_x;
	logic [COORD_BITS-1:0]          pixel_y;
	logic [lr_pkg::COLOR_BITS-1:0]  pixel_color;
	logic                           last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
	modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/line_rasterizer.sv =====
// Line rasterizer top level: joins the segment and pixel channels to the
// controller and datapath. Depends on lr_pkg, lr_seg_if, lr_pix_if, lr_ctrl, lr_datapath.
//
// Usage:
//   segment: one request per line, two endpoints and a color. It is taken only
//   while the block is idle, i.e. after the last pixel of the previous line left.
//   pixel:   one request per pixel, with last_pixel set on the final one.
// Timing:
//   Horizontal, vertical and single-point lines: after the segment is taken,
//   the controller passes through ST_DIVIDE without dividing and offers the
//   first pixel in ST_EMIT. Sloped lines first run the slope through a
//   restoring divider, one quotient bit per cycle, then pass ST_FIX before
//   the first pixel is offered in ST_EMIT. Pixels then follow at one per
//   cycle while ready is high; a line has at most 2^COORD_BITS - 1.
// Reset:
//   arst_n clears the controller to idle; any line in flight is dropped.
// Stall:
//   While the pixel receiver holds ready low, the current pixel holds on the
//   port and stepping stops; no pixel is lost or repeated.
`default_nettype none

module line_rasterizer #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	lr_seg_if.sink   segment,
	lr_pix_if.source pixel
);

	lr_pkg::lr_cmd_t cmd;
	lr_pkg::lr_sts_t sts;

	lr_ctrl #(
		.COORD_BITS (COORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (segment.valid),
		.seg_ready (segment.ready),
		.pix_valid (pixel.valid),
		.pix_ready (pixel.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lr_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk         (clk),
		.cmd         (cmd),
		.sts         (sts),
		.start_x     (segment.start_x),
		.start_y     (segment.start_y),
		.end_x       (segment.end_x),
		.end_y       (segment.end_y),
		.line_color  (segment.line_color),
		.pixel_x     (pixel.pixel_x),
		.pixel_y     (pixel.pixel_y),
		.pixel_color (pixel.pixel_color),
		.last_pixel  (pixel.last_pixel)
	);

endmodule

`default_nettype wire

// ===== rtl/lr_ctrl.sv =====
// Line rasterizer controller: sequences load, slope division, fixup and pixel emission.
// Depends on lr_pkg for the command and status structs.
`default_nettype none

module lr_ctrl #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            seg_valid,
	output logic                 seg_ready,
	output logic                 pix_valid,
	input  wire logic            pix_ready,
	input  wire lr_pkg::lr_sts_t sts,
	output lr_pkg::lr_cmd_t      cmd
);

	localparam int CW = $clog2(COORD_BITS);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DIVIDE = 4'b0010,
		ST_FIX    = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		cmd       = '0;
		seg_ready = 1'b0;
		pix_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				seg_ready = 1'b1;
				if (seg_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (!sts.general) begin
					state_d = ST_EMIT;
				end else begin
					cmd.div_step = 1'b1;
					if (cnt_q == CW'(COORD_BITS - 1)) begin
						state_d = ST_FIX;
					end else begin
						cnt_d = cnt_q + CW'(1);
					end
				end
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				pix_valid = 1'b1;
				if (pix_ready) begin
					cmd.advance = 1'b1;
					if (sts.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lr_datapath.sv =====
// Line rasterizer datapath: segment setup, restoring slope divider and
// the incremental pixel stepper. Depends on lr_pkg for structs and widths.
`default_nettype none

module lr_datapath #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire lr_pkg::lr_cmd_t               cmd,
	output lr_pkg::lr_sts_t                    sts,
	input  wire logic [COORD_BITS-1:0]         start_x,
	input  wire logic [COORD_BITS-1:0]         start_y,
	input  wire logic [COORD_BITS-1:0]         end_x,
	input  wire logic [COORD_BITS-1:0]         end_y,
	input  wire logic [lr_pkg::COLOR_BITS-1:0] line_color,
	output logic [COORD_BITS-1:0]              pixel_x,
	output logic [COORD_BITS-1:0]              pixel_y,
	output logic [lr_pkg::COLOR_BITS-1:0]      pixel_color,
	output logic                               last_pixel
);

	localparam int C = COORD_BITS;

	logic [lr_pkg::COLOR_BITS-1:0] color_q;
	logic [C-1:0]  x_q, y_q, count_q, adx_q, rem_q, quo_q;
	logic [C:0]    r_q, twoadx_q, rstep_q;
	logic signed [C:0] qstep_q;
	logic          xmove_q, xneg_q, dyneg_q, general_q;

	logic          x_lt, y_lt, xeq, yeq;
	logic [C-1:0]  dxa, dya;
	logic [C:0]    trial;
	logic          trial_ge;
	logic [C-1:0]  rem_next;
	logic signed [C:0] fix_q;
	logic [C-1:0]  fix_rm;
	logic [C+1:0]  rsum;
	logic          carry;
	logic [C:0]    y_sum;
	logic [C-1:0]  x_next;

	always_comb begin
		x_lt = start_x < end_x;
		y_lt = start_y < end_y;
		xeq  = start_x == end_x;
		yeq  = start_y == end_y;
		dxa  = x_lt ? end_x - start_x : start_x - end_x;
		dya  = y_lt ? end_y - start_y : start_y - end_y;
	end

	always_comb begin
		trial    = {rem_q, quo_q[C-1]};
		trial_ge = trial >= {1'b0, adx_q};
		rem_next = trial_ge ? C'(trial - {1'b0, adx_q}) : trial[C-1:0];
	end

	always_comb begin
		if (!dyneg_q) begin
			fix_q  = $signed({1'b0, quo_q});
			fix_rm = rem_q;
		end else if (rem_q == '0) begin
			fix_q  = -$signed({1'b0, quo_q});
			fix_rm = '0;
		end else begin
			fix_q  = -$signed({1'b0, quo_q} + (C+1)'(1));
			fix_rm = adx_q - rem_q;
		end
	end

	always_comb begin
		rsum   = {1'b0, r_q} + {1'b0, rstep_q};
		carry  = general_q && (rsum >= {1'b0, twoadx_q});
		y_sum  = {1'b0, y_q} + qstep_q + {{C{1'b0}}, carry};
		if (!xmove_q) begin
			x_next = x_q;
		end else if (xneg_q) begin
			x_next = x_q - C'(1);
		end else begin
			x_next = x_q + C'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			color_q   <= line_color;
			adx_q     <= dxa;
			rem_q     <= '0;
			quo_q     <= dya;
			dyneg_q   <= end_y < start_y;
			general_q <= !xeq && !yeq;
			r_q       <= {1'b0, dxa};
			twoadx_q  <= {dxa, 1'b0};
			rstep_q   <= '0;
			if (xeq && yeq) begin
				x_q     <= end_x;
				y_q     <= end_y;
				count_q <= C'(1);
				xmove_q <= 1'b0;
				xneg_q  <= 1'b0;
				qstep_q <= '0;
			end else if (yeq) begin
				x_q     <= x_lt ? start_x : end_x;
				y_q     <= start_y;
				count_q <= dxa;
				xmove_q <= 1'b1;
				xneg_q  <= 1'b0;
				qstep_q <= '0;
			end else if (xeq) begin
				x_q     <= start_x;
				y_q     <= y_lt ? start_y : end_y;
				count_q <= dya;
				xmove_q <= 1'b0;
				xneg_q  <= 1'b0;
				qstep_q <= (C+1)'(1);
			end else begin
				x_q     <= start_x;
				y_q     <= start_y;
				count_q <= dxa;
				xmove_q <= 1'b1;
				xneg_q  <= !x_lt;
				qstep_q <= '0;
			end
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[C-2:0], trial_ge};
		end else if (cmd.fix) begin
			qstep_q <= fix_q;
			rstep_q <= {fix_rm, 1'b0};
		end else if (cmd.advance) begin
			x_q     <= x_next;
			y_q     <= y_sum[C-1:0];
			r_q     <= carry ? (C+1)'(rsum - {1'b0, twoadx_q}) : rsum[C:0];
			count_q <= count_q - C'(1);
		end
	end

	assign sts.general = general_q;
	assign sts.last    = count_q == C'(1);

	assign pixel_x     = x_q;
	assign pixel_y     = y_q;
	assign pixel_color = color_q;
	assign last_pixel  = count_q == C'(1);

endmodule

`default_nettype wire
